// ===== sv/barst_pkg.sv =====
package barst_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_EXPAND = 2'd1,
        OP_RAY    = 2'd2
    } op_t;

    localparam int STAGES = 7;

    // one enable per pipeline stage, in pipeline order
    typedef struct packed {
        logic sub;
        logic mul;
        logic mid;
        logic sum;
        logic sat;
        logic mrg;
        logic out;
    } adv_t;

endpackage

// ===== sv/barst_slab_mul.sv =====
module barst_slab_mul #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  barst_pkg::adv_t               adv,
    input  logic signed [COORD_WIDTH:0]   a,
    input  logic signed [COORD_WIDTH-1:0] b,
    output logic signed [2*COORD_WIDTH:0] prod
);
    import barst_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = DW + COORD_WIDTH;
    localparam int AL = DW / 2;
    localparam int AH = DW - AL;
    localparam int BL = COORD_WIDTH / 2;
    localparam int BH = COORD_WIDTH - BL;

    logic        [AL+BL-1:0] pll_reg;
    logic signed [AL+BH:0]   plh_reg;
    logic signed [AH+BL:0]   phl_reg;
    logic signed [AH+BH-1:0] phh_reg;
    logic signed [PW-1:0]    cat_reg;
    logic signed [PW-1:0]    mid_reg;
    logic signed [PW-1:0]    prod_reg;

    // limb products: low limbs unsigned, high limbs signed
    always_ff @(posedge clk)
    begin
        if (adv.mul)
        begin
            pll_reg <= a[AL-1:0] * b[BL-1:0];
            plh_reg <= $signed({1'b0, a[AL-1:0]}) * $signed(b[COORD_WIDTH-1:BL]);
            phl_reg <= $signed(a[DW-1:AL]) * $signed({1'b0, b[BL-1:0]});
            phh_reg <= $signed(a[DW-1:AL]) * $signed(b[COORD_WIDTH-1:BL]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.mid)
        begin
            cat_reg <= {phh_reg, pll_reg};
            mid_reg <= (PW'(plh_reg) <<< BL) + (PW'(phl_reg) <<< AL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.sum)
        begin
            prod_reg <= cat_reg + mid_reg;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== sv/barst_lane.sv =====
module barst_lane #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  barst_pkg::adv_t         adv,
    input  logic                    xfer,
    input  barst_pkg::op_t          opcode,
    input  logic [COORD_WIDTH-1:0]  coord,
    input  logic [COORD_WIDTH-1:0]  inv_dir,
    output logic [COORD_WIDTH-1:0]  near,
    output logic [COORD_WIDTH-1:0]  far
);
    import barst_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * COORD_WIDTH + 1;
    localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [COORD_WIDTH-1:0] box_low_reg, box_low_next;
    logic signed [COORD_WIDTH-1:0] box_high_reg, box_high_next;
    logic signed [COORD_WIDTH-1:0] c_s;
    logic signed [DW-1:0]          dlo_reg, dhi_reg;
    logic signed [COORD_WIDTH-1:0] inv_reg;
    logic signed [PW-1:0]          plo, phi;
    logic signed [COORD_WIDTH-1:0] t1, t2;
    logic signed [COORD_WIDTH-1:0] near_reg, far_reg;

    // floor shift, then clamp to the coordinate range
    function automatic logic signed [COORD_WIDTH-1:0] sat_q(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] q;
        q = p >>> FRAC_BITS;
        if ((&q[PW-1:COORD_WIDTH-1]) || !(|q[PW-1:COORD_WIDTH-1]))
            sat_q = q[COORD_WIDTH-1:0];
        else
            sat_q = q[PW-1] ? C_MIN : C_MAX;
    endfunction

    assign c_s = coord;

    always_comb
    begin
        box_low_next  = box_low_reg;
        box_high_next = box_high_reg;
        case (opcode)
            OP_CLEAR:
            begin
                box_low_next  = C_MAX;
                box_high_next = C_MIN;
            end
            OP_EXPAND:
            begin
                if (c_s < box_low_reg)
                    box_low_next = c_s;
                if (c_s > box_high_reg)
                    box_high_next = c_s;
            end
            default:
            begin
                box_low_next  = box_low_reg;
                box_high_next = box_high_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_low_reg  <= C_MAX;
            box_high_reg <= C_MIN;
        end
        else if (xfer)
        begin
            box_low_reg  <= box_low_next;
            box_high_reg <= box_high_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.sub)
        begin
            dlo_reg <= DW'(box_low_reg) - DW'(c_s);
            dhi_reg <= DW'(box_high_reg) - DW'(c_s);
            inv_reg <= inv_dir;
        end
    end

    barst_slab_mul #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_mul_lo (
        .clk (clk),
        .adv (adv),
        .a   (dlo_reg),
        .b   (inv_reg),
        .prod(plo)
    );

    barst_slab_mul #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_mul_hi (
        .clk (clk),
        .adv (adv),
        .a   (dhi_reg),
        .b   (inv_reg),
        .prod(phi)
    );

    assign t1 = sat_q(plo);
    assign t2 = sat_q(phi);

    always_ff @(posedge clk)
    begin
        if (adv.sat)
        begin
            near_reg <= (t1 < t2) ? t1 : t2;
            far_reg  <= (t1 < t2) ? t2 : t1;
        end
    end

    assign near = near_reg;
    assign far  = far_reg;

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && opcode == OP_CLEAR |=> box_low_reg == C_MAX && box_high_reg == C_MIN)
        else $error("box not emptied by clear");

    a_expand_orders: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && opcode == OP_EXPAND |=> box_low_reg <= box_high_reg)
        else $error("box corners out of order after expand");

    a_other_holds: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && !(opcode == OP_CLEAR || opcode == OP_EXPAND)
        |=> $stable(box_low_reg) && $stable(box_high_reg))
        else $error("box changed by a ray or unused opcode");

endmodule

// ===== sv/barst_merge.sv =====
module barst_merge #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                        clk,
    input  barst_pkg::adv_t             adv,
    input  logic [2:0][COORD_WIDTH-1:0] near,
    input  logic [2:0][COORD_WIDTH-1:0] far,
    output logic                        hit,
    output logic [COORD_WIDTH-1:0]      t_enter,
    output logic [COORD_WIDTH-1:0]      t_exit
);
    import barst_pkg::*;

    logic signed [COORD_WIDTH-1:0] enter_c, exit_c;
    logic signed [COORD_WIDTH-1:0] enter_reg, exit_reg;
    logic signed [COORD_WIDTH-1:0] t_enter_reg, t_exit_reg;
    logic                          hit_reg;

    always_comb
    begin
        enter_c = near[0];
        exit_c  = far[0];
        for (int i = 1; i < 3; i++)
        begin
            if ($signed(near[i]) > enter_c)
                enter_c = near[i];
            if ($signed(far[i]) < exit_c)
                exit_c = far[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.mrg)
        begin
            enter_reg <= enter_c;
            exit_reg  <= exit_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.out)
        begin
            hit_reg     <= !(exit_reg < 0 || enter_reg > exit_reg);
            t_enter_reg <= enter_reg;
            t_exit_reg  <= exit_reg;
        end
    end

    assign hit     = hit_reg;
    assign t_enter = t_enter_reg;
    assign t_exit  = t_exit_reg;

endmodule

// ===== sv/box_accumulate_ray_slab_test.sv =====
// Ray against accumulated box, slab test, one lane per axis.
// Pipeline: a ray transfer passes the subtract, limb multiply, two adds,
// clamp, merge and output registers. One item per cycle while the output
// is not stalled; clear and expand update the box on transfer.
// Reset: box empty (low corner at the largest value, high at the least),
// pipeline empty, no clearing pass.
module box_accumulate_ray_slab_test #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // coord_x, coord_y, coord_z, inv_dir_x, inv_dir_y, inv_dir_z, zero pad
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // opcode
    input  logic [1:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // t_enter, t_exit, zero pad
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    // hit
    output logic [0:0]                            m_axis_tuser
);
    import barst_pkg::*;

    localparam int ODW = ((2*COORD_WIDTH+7)/8)*8;

    logic [STAGES-1:0]            v_reg, v_next;
    logic [STAGES-1:0]            rdy;
    logic                         v_in;
    logic                         xfer;
    adv_t                         adv;
    logic [2:0][COORD_WIDTH-1:0]  near, far;
    logic                         hit;
    logic [COORD_WIDTH-1:0]       t_enter, t_exit;

    assign v_in = s_axis_tvalid && (s_axis_tuser == OP_RAY);
    assign xfer = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        rdy[STAGES-1] = !v_reg[STAGES-1] || m_axis_tready;
        for (int i = STAGES - 2; i >= 0; i--)
            rdy[i] = !v_reg[i] || rdy[i+1];
    end

    always_comb
    begin
        v_next[0] = rdy[0] ? v_in : v_reg[0];
        for (int i = 1; i < STAGES; i++)
            v_next[i] = rdy[i] ? v_reg[i-1] : v_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign adv.sub = rdy[0];
    assign adv.mul = rdy[1];
    assign adv.mid = rdy[2];
    assign adv.sum = rdy[3];
    assign adv.sat = rdy[4];
    assign adv.mrg = rdy[5];
    assign adv.out = rdy[6];

    generate
        for (genvar g = 0; g < 3; g++)
        begin : g_lane
            barst_lane #(
                .COORD_WIDTH(COORD_WIDTH),
                .FRAC_BITS  (FRAC_BITS)
            ) u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .adv    (adv),
                .xfer   (xfer),
                .opcode (op_t'(s_axis_tuser)),
                .coord  (s_axis_tdata[g*COORD_WIDTH +: COORD_WIDTH]),
                .inv_dir(s_axis_tdata[(g+3)*COORD_WIDTH +: COORD_WIDTH]),
                .near   (near[g]),
                .far    (far[g])
            );
        end
    endgenerate

    barst_merge #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_merge (
        .clk    (clk),
        .adv    (adv),
        .near   (near),
        .far    (far),
        .hit    (hit),
        .t_enter(t_enter),
        .t_exit (t_exit)
    );

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = v_reg[STAGES-1];
    assign m_axis_tdata  = ODW'({t_exit, t_enter});
    assign m_axis_tuser  = hit;

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> &v_reg)
        else $error("input stalled with a bubble in the pipeline");

    a_no_ray_no_item: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && s_axis_tuser != OP_RAY |=> !v_reg[0])
        else $error("non-ray transfer entered the pipeline");

    a_out_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v_reg[STAGES-1]) |-> $past(v_reg[STAGES-2]))
        else $error("result appeared without a merged item");

    a_hit_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0]
        |-> !$signed(t_exit[COORD_WIDTH-1]) && ($signed(t_enter) <= $signed(t_exit)))
        else $error("hit flagged for a miss interval");

endmodule
